@@ sv/ldsr_pkg.sv @@
`default_nettype none

package ldsr_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_START = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MODE,
		PH_DATA,
		PH_ADDR,
		PH_ADDR0,
		PH_CTRL,
		PH_FINISH
	} phase_t;

	typedef enum logic [1:0] {
		ST_STB_LOW,
		ST_CLK_LOW,
		ST_CLK_HIGH,
		ST_STB_HIGH
	} step_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_CMD    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DATA_CMD    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ADDR_BASE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CTRL_CMD    = 3'd4;

	localparam logic [7:0] RST_HALF_PERIOD = 8'h01;
	localparam logic [7:0] RST_MODE_CMD    = 8'h02;
	localparam logic [7:0] RST_DATA_CMD    = 8'h44;
	localparam logic [7:0] RST_ADDR_BASE   = 8'hc0;
	localparam logic [7:0] RST_CTRL_CMD    = 8'h8c;

endpackage

`default_nettype wire

@@ sv/led_driver_serial_refresh.sv @@
// an accepted item's result is registered into the output register
// throughput: one item per cycle unless m_tready stalls the output, the next state
// is computed in a single pass and the output register is refilled while its result is taken
// reset: arst_n clears the sequencer to idle, pins high, store zero and the
// configuration registers to their defaults
`default_nettype none

module led_driver_serial_refresh #(
	parameter int STORE_BYTES = 5
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// digit_index [2:0], byte_value [10:3], zero [15:11]
	input  wire logic [15:0]                       s_tdata,
	// mode [1:0]
	input  wire logic [1:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// clock_pin [0], data_pin [1], strobe_pin [2], busy_res [3], zero [7:4]
	output logic [7:0]                             m_tdata,
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [ldsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ldsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic [7:0] half_period_q, mode_cmd_q, data_cmd_q, addr_base_q, ctrl_cmd_q;
	logic [7:0] store_q [STORE_BYTES];

	ldsr_pkg::phase_t phase_q, phase_d;
	ldsr_pkg::step_t  step_q, step_d;
	logic [IW-1:0]    tcount_q, tcount_d;
	logic [2:0]       bcount_q, bcount_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       delay_q, delay_d;
	logic             second_q, second_d;
	logic             clk_pin_q, clk_pin_d;
	logic             dat_pin_q, dat_pin_d;
	logic             stb_pin_q, stb_pin_d;
	logic             done_d;

	logic             accept;
	logic [1:0]       mode_in;
	logic [2:0]       digit_in;
	logic [7:0]       byte_in;
	logic [7:0]       hold;
	logic [7:0]       cmd;
	logic [7:0]       store_rd;
	logic             last;

	assign mode_in  = s_tuser;
	assign digit_in = s_tdata[2:0];
	assign byte_in  = s_tdata[10:3];
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign hold = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
	assign store_rd = (int'(tcount_q) < STORE_BYTES) ? store_q[tcount_q] : store_q[0];

	always_comb begin
		unique case (phase_q)
			ldsr_pkg::PH_MODE:  cmd = mode_cmd_q;
			ldsr_pkg::PH_DATA:  cmd = data_cmd_q;
			ldsr_pkg::PH_ADDR:  cmd = addr_base_q + 8'({tcount_q, 1'b0});
			ldsr_pkg::PH_ADDR0: cmd = addr_base_q;
			default:            cmd = ctrl_cmd_q;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		step_d    = step_q;
		tcount_d  = tcount_q;
		bcount_d  = bcount_q;
		shift_d   = shift_q;
		delay_d   = delay_q;
		second_d  = second_q;
		clk_pin_d = clk_pin_q;
		dat_pin_d = dat_pin_q;
		stb_pin_d = stb_pin_q;
		done_d    = 1'b0;
		last      = 1'b0;
		unique case (ldsr_pkg::mode_t'(mode_in))
			ldsr_pkg::MODE_START: begin
				if (phase_q == ldsr_pkg::PH_IDLE) begin
					phase_d  = ldsr_pkg::PH_MODE;
					step_d   = ldsr_pkg::ST_STB_LOW;
					tcount_d = '0;
					bcount_d = '0;
					delay_d  = '0;
					second_d = 1'b0;
				end
			end
			ldsr_pkg::MODE_TICK: begin
				if (phase_q != ldsr_pkg::PH_IDLE) begin
					if (delay_q != 8'd0) begin
						delay_d = delay_q - 8'd1;
						if (delay_q == 8'd1 && phase_q == ldsr_pkg::PH_FINISH) begin
							phase_d = ldsr_pkg::PH_IDLE;
							done_d  = 1'b1;
						end
					end else begin
						unique case (step_q)
							ldsr_pkg::ST_STB_LOW: begin
								stb_pin_d = 1'b0;
								shift_d   = cmd;
								bcount_d  = '0;
								second_d  = 1'b0;
								step_d    = ldsr_pkg::ST_CLK_LOW;
							end
							ldsr_pkg::ST_CLK_LOW: begin
								clk_pin_d = 1'b0;
								dat_pin_d = shift_q[0];
								step_d    = ldsr_pkg::ST_CLK_HIGH;
							end
							ldsr_pkg::ST_CLK_HIGH: begin
								clk_pin_d = 1'b1;
								shift_d   = {1'b0, shift_q[7:1]};
								if (bcount_q == 3'd7) begin
									bcount_d = '0;
									if ((phase_q == ldsr_pkg::PH_ADDR ||
									     phase_q == ldsr_pkg::PH_ADDR0) && !second_q) begin
										second_d = 1'b1;
										shift_d  = (phase_q == ldsr_pkg::PH_ADDR) ?
										           store_rd : store_q[0];
										step_d   = ldsr_pkg::ST_CLK_LOW;
									end else begin
										step_d = ldsr_pkg::ST_STB_HIGH;
									end
								end else begin
									bcount_d = bcount_q + 3'd1;
									step_d   = ldsr_pkg::ST_CLK_LOW;
								end
							end
							ldsr_pkg::ST_STB_HIGH: begin
								stb_pin_d = 1'b1;
								second_d  = 1'b0;
								step_d    = ldsr_pkg::ST_STB_LOW;
								unique case (phase_q)
									ldsr_pkg::PH_MODE: phase_d = ldsr_pkg::PH_DATA;
									ldsr_pkg::PH_DATA: begin
										phase_d  = ldsr_pkg::PH_ADDR;
										tcount_d = '0;
									end
									ldsr_pkg::PH_ADDR: begin
										if (int'(tcount_q) >= STORE_BYTES - 1) begin
											tcount_d = '0;
											phase_d  = ldsr_pkg::PH_ADDR0;
										end else begin
											tcount_d = tcount_q + IW'(1);
										end
									end
									ldsr_pkg::PH_ADDR0: phase_d = ldsr_pkg::PH_CTRL;
									default: begin
										phase_d = ldsr_pkg::PH_FINISH;
										last    = 1'b1;
									end
								endcase
							end
						endcase
						delay_d = hold - 8'd1;
						if (last && hold == 8'd1) begin
							phase_d = ldsr_pkg::PH_IDLE;
							done_d  = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= ldsr_pkg::RST_HALF_PERIOD;
			mode_cmd_q    <= ldsr_pkg::RST_MODE_CMD;
			data_cmd_q    <= ldsr_pkg::RST_DATA_CMD;
			addr_base_q   <= ldsr_pkg::RST_ADDR_BASE;
			ctrl_cmd_q    <= ldsr_pkg::RST_CTRL_CMD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ldsr_pkg::REG_HALF_PERIOD: half_period_q <= cfg_data;
				ldsr_pkg::REG_MODE_CMD:    mode_cmd_q    <= cfg_data;
				ldsr_pkg::REG_DATA_CMD:    data_cmd_q    <= cfg_data;
				ldsr_pkg::REG_ADDR_BASE:   addr_base_q   <= cfg_data;
				ldsr_pkg::REG_CTRL_CMD:    ctrl_cmd_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (accept && mode_in == ldsr_pkg::MODE_WRITE) begin
			for (int i = 0; i < STORE_BYTES; i++) begin
				if (int'(digit_in) == i) begin
					store_q[i] <= byte_in;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ldsr_pkg::PH_IDLE;
			step_q    <= ldsr_pkg::ST_STB_LOW;
			tcount_q  <= '0;
			bcount_q  <= '0;
			shift_q   <= '0;
			delay_q   <= '0;
			second_q  <= 1'b0;
			clk_pin_q <= 1'b1;
			dat_pin_q <= 1'b1;
			stb_pin_q <= 1'b1;
		end else if (accept) begin
			phase_q   <= phase_d;
			step_q    <= step_d;
			tcount_q  <= tcount_d;
			bcount_q  <= bcount_d;
			shift_q   <= shift_d;
			delay_q   <= delay_d;
			second_q  <= second_d;
			clk_pin_q <= clk_pin_d;
			dat_pin_q <= dat_pin_d;
			stb_pin_q <= stb_pin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= {4'b0000, (phase_d != ldsr_pkg::PH_IDLE), stb_pin_d, dat_pin_d,
			            clk_pin_d};
			m_tlast <= done_d;
		end
	end

endmodule

`default_nettype wire
